>>> design/xtdc_pkg.sv
// ----------------------------------------------------------------------------
// xtdc_pkg
// Shared types, constants and lookup functions of the XT disk controller port.
// ----------------------------------------------------------------------------
package xtdc_pkg;

	localparam int SECTOR_BYTES  = 512;
	localparam int COMMAND_BYTES = 6;
	localparam int SENSE_BYTES   = 14;

	localparam int XFER_W   = $clog2(SECTOR_BYTES + 1);
	localparam int SECT_AW  = $clog2(SECTOR_BYTES);
	localparam int CMD_W    = $clog2(COMMAND_BYTES);
	localparam int SENSE_W  = $clog2(SENSE_BYTES + 1);
	localparam int ADDR_W   = 4;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int SENSE_DRIVE_IDX = 12;
	localparam int BOOT_LEN        = 10;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [ADDR_W-1:0] ADDR_DATA = 4'd0;
	localparam logic [ADDR_W-1:0] ADDR_MASK = 4'd2;
	localparam logic [ADDR_W-1:0] ADDR_STAT = 4'd4;
	localparam logic [ADDR_W-1:0] ADDR_DMA  = 4'd8;

	localparam logic [7:0] OPC_DMA_READ = 8'h15;
	localparam logic [7:0] REG2_VALUE   = 8'h12;
	localparam logic [7:0] REG0_RESET   = 8'h05;
	localparam logic [7:0] REG8_RESET   = 8'h52;
	localparam logic [7:0] FILL_BYTE    = 8'h20;
	localparam logic [7:0] SIG_LO       = 8'h55;
	localparam logic [7:0] SIG_HI       = 8'haa;

	localparam int CTRL_RESET_BIT = 7;
	localparam int CTRL_SENSE_BIT = 5;

	localparam logic REG_HD_TYPE = 1'b0;
	localparam logic [7:0] HD_TYPE_RESET = 8'd4;

	localparam logic [1:0] PEND_DRQ = 2'b01;
	localparam logic [1:0] PEND_IRQ = 2'b10;

	typedef struct packed {
		logic       op;
		logic [2:0] port;
		logic       dma_ack;
		logic [7:0] write_byte;
	} access_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       irq_line;
		logic       drq_line;
	} result_t;

	localparam logic [7:0] BOOT_CODE [BOOT_LEN] = '{
		8'hb8, 8'h52, 8'h0e, 8'hbb, 8'h00, 8'h00, 8'hcd, 8'h10, 8'heb, 8'hfe
	};

	function automatic logic [7:0] rom_byte(input logic [SECT_AW-1:0] idx);
		logic [7:0] b;
		b = FILL_BYTE;
		if (int'(idx) < BOOT_LEN) begin
			b = BOOT_CODE[int'(idx)];
		end else if (int'(idx) == SECTOR_BYTES - 2) begin
			b = SIG_LO;
		end else if (int'(idx) == SECTOR_BYTES - 1) begin
			b = SIG_HI;
		end
		return b;
	endfunction

	function automatic logic [7:0] sense_byte(input logic [SENSE_W-1:0] idx,
			input logic [7:0] hd_type);
		return (int'(idx) == SENSE_DRIVE_IDX) ? hd_type : 8'd0;
	endfunction

endpackage

>>> design/xt_disk_controller_port_core.sv
// ----------------------------------------------------------------------------
// xt_disk_controller_port_core
// Host bus side of an XT style fixed disk controller.
// ----------------------------------------------------------------------------
// One host access is taken per clock while the input is not stalled. It lands
// in the input register, and its result is then loaded into the result
// register, from which it is offered. The whole controller update for an
// access is one pass of logic between those two registers, so accesses stream
// back to back at one per cycle while the result side is not stalled; with the
// result side stalled the block holds two items and then stalls its input. No
// clearing pass is needed after reset.
module xt_disk_controller_port_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        access_valid,
	output logic                        access_stall,
	input  xtdc_pkg::access_t           access,
	output logic                        result_valid,
	input  logic                        result_stall,
	output xtdc_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xtdc_pkg::APB_AW-1:0] paddr,
	input  logic [xtdc_pkg::APB_DW-1:0] pwdata,
	output logic [xtdc_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import xtdc_pkg::*;

	logic      valid_s1, result_valid_q, advance, fire;
	access_t   item_s1;
	result_t   result_q, exec_result;
	logic [7:0] hd_type;

	assign advance      = !result_valid_q || !result_stall;
	assign fire         = valid_s1 && advance;
	assign access_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!access_stall) begin
				valid_s1 <= access_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (access_valid && !access_stall) begin
			item_s1 <= access;
		end
		if (fire) begin
			result_q <= exec_result;
		end
	end

	xtdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.hd_type (hd_type)
	);

	xtdc_exec u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.access  (item_s1),
		.hd_type (hd_type),
		.result  (exec_result)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> design/xtdc_regs.sv
// ----------------------------------------------------------------------------
// xtdc_regs
// APB configuration register: drive type code reported in the sense block.
// ----------------------------------------------------------------------------
module xtdc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [xtdc_pkg::APB_AW-1:0] paddr,
	input  logic [xtdc_pkg::APB_DW-1:0] pwdata,
	output logic [xtdc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [7:0]                 hd_type
);
	import xtdc_pkg::*;

	logic [7:0] hd_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_type_q <= HD_TYPE_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_HD_TYPE)) begin
			hd_type_q <= pwdata[7:0];
		end
	end

	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == REG_HD_TYPE) ? {{(APB_DW-8){1'b0}}, hd_type_q}
	                                           : '0;
	assign hd_type = hd_type_q;

endmodule

>>> design/xtdc_exec.sv
// ----------------------------------------------------------------------------
// xtdc_exec
// Controller state and the per-access update: command intake, sense readout,
// sector DMA streaming and request lines.
// ----------------------------------------------------------------------------
module xtdc_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  xtdc_pkg::access_t access,
	input  logic [7:0]        hd_type,
	output xtdc_pkg::result_t result
);
	import xtdc_pkg::*;

	logic [7:0]         reg0_q, reg8_q, cmd0_q, mask_q;
	logic [CMD_W-1:0]   count_q;
	logic [SENSE_W-1:0] sense_q;
	logic [XFER_W-1:0]  xfer_q;
	logic [1:0]         pend_q;

	logic [7:0]         reg0_d, reg8_d, cmd0_d, mask_d, rd;
	logic [CMD_W-1:0]   count_d;
	logic [SENSE_W-1:0] sense_d;
	logic [XFER_W-1:0]  xfer_d;
	logic [1:0]         pend_d;
	logic [ADDR_W-1:0]  addr;
	logic [7:0]         data;

	always_comb begin
		addr    = access.dma_ack ? ADDR_DMA : {1'b0, access.port};
		data    = access.write_byte;
		reg0_d  = reg0_q;
		reg8_d  = reg8_q;
		cmd0_d  = cmd0_q;
		mask_d  = mask_q;
		count_d = count_q;
		sense_d = sense_q;
		xfer_d  = xfer_q;
		pend_d  = pend_q;
		rd      = 8'd0;
		if (access.op == OP_WRITE) begin
			if (addr == ADDR_DATA) begin
				if (count_q == CMD_W'(0)) begin
					cmd0_d = data;
				end
				if (count_q == CMD_W'(COMMAND_BYTES - 1)) begin
					count_d = '0;
					if (cmd0_q == OPC_DMA_READ) begin
						reg8_d = rom_byte('0);
						xfer_d = XFER_W'(1);
						pend_d = pend_d | PEND_DRQ;
					end
					pend_d = pend_d | PEND_IRQ;
				end else begin
					count_d = count_q + CMD_W'(1);
				end
			end else if (addr == ADDR_MASK) begin
				if (data[CTRL_RESET_BIT]) begin
					count_d = '0;
					pend_d  = PEND_IRQ;
				end
				mask_d = data;
			end else if (addr == ADDR_STAT) begin
				if (data[CTRL_RESET_BIT]) begin
					count_d = '0;
					pend_d  = '0;
				end
				if (data[CTRL_SENSE_BIT]) begin
					reg0_d  = sense_byte('0, hd_type);
					sense_d = SENSE_W'(1);
				end
			end
		end else begin
			if (addr == ADDR_DATA) begin
				rd = reg0_q;
				if (int'(sense_q) < SENSE_BYTES) begin
					reg0_d  = sense_byte(sense_q, hd_type);
					sense_d = sense_q + SENSE_W'(1);
				end
			end else if (addr == ADDR_MASK) begin
				rd = REG2_VALUE;
			end else if (addr == ADDR_DMA) begin
				rd = reg8_q;
				if (int'(xfer_q) >= SECTOR_BYTES) begin
					pend_d = pend_q & ~PEND_DRQ;
				end else begin
					reg8_d = rom_byte(xfer_q[SECT_AW-1:0]);
					xfer_d = xfer_q + XFER_W'(1);
				end
			end
		end
		result.read_byte = rd;
		result.irq_line  = pend_d[1] & mask_d[1];
		result.drq_line  = pend_d[0] & mask_d[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg0_q  <= REG0_RESET;
			reg8_q  <= REG8_RESET;
			mask_q  <= '0;
			count_q <= '0;
			sense_q <= '0;
			xfer_q  <= '0;
			pend_q  <= '0;
		end else if (fire) begin
			reg0_q  <= reg0_d;
			reg8_q  <= reg8_d;
			mask_q  <= mask_d;
			count_q <= count_d;
			sense_q <= sense_d;
			xfer_q  <= xfer_d;
			pend_q  <= pend_d;
		end
	end

	// opcode byte, always written before a command can run
	always_ff @(posedge clk) begin
		if (fire) begin
			cmd0_q <= cmd0_d;
		end
	end

endmodule
